/* rtl/huffman_sorted_priority_queue_unit_defines.svh */
// Assertion macros used by the sorted priority queue top level.
`ifndef HUFFMAN_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define HUFFMAN_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising clk edge outside of reset.
`define HSPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hspq assertion failed");

// Checked on every rising clk edge, reset included.
`define HSPQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hspq assertion failed");

`else

`define HSPQ_ASSERT(label, prop)
`define HSPQ_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* rtl/hspq_pkg.sv */
// Shared types and constants of the sorted priority queue.
package hspq_pkg;

  localparam int CAPACITY    = 256;
  localparam int WEIGHT_BITS = 32;
  localparam int SYMBOL_BITS = 8;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int GROUP_SIZE  = 16;
  localparam int GROUP_COUNT = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic {
    FUNC_ENQUEUE = 1'b0,
    FUNC_DEQUEUE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    func_t                  func;
    logic [SYMBOL_BITS-1:0] symbol;
    logic [WEIGHT_BITS-1:0] weight;
  } in_t;

  typedef struct packed {
    status_t                status;
    logic [SYMBOL_BITS-1:0] out_symbol;
    logic [WEIGHT_BITS-1:0] out_weight;
    logic [CNT_W-1:0]       occupancy;
  } out_t;

  // Control that the sequencer broadcasts to every cell of the chain.
  typedef struct packed {
    logic capture;
    logic insert;
    logic remove;
  } cell_ctl_t;

endpackage

/* rtl/huffman_sorted_priority_queue_unit.sv */
// Top level of the sorted priority queue: sequencer, count and the chain of cells.
//
// Each item (enqueue or dequeue) passes through the compare, gather and apply
// states: busy rises after the accepting edge and falls when done is high for
// exactly one cycle with the result, and the next item can be accepted in that
// same cycle. In the compare state every cell compares its weight and symbol
// against the item and registers the flags, in the gather state a registered OR
// tree gathers the duplicate flags, and the apply state decides the status and
// shifts the entries behind the insert point (on a dequeue, the whole chain) by
// one slot at once. The receiver cannot stall the result, so it must take it
// while done is high. Slots beyond the occupancy are never read out; a dequeue
// on an empty queue and every non-dequeue result give zero symbol and weight.
`include "huffman_sorted_priority_queue_unit_defines.svh"

module huffman_sorted_priority_queue_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  hspq_pkg::in_t  cmd,
  output logic           done,
  output hspq_pkg::out_t result
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_RED   = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  localparam int N  = hspq_pkg::CAPACITY;
  localparam int SB = hspq_pkg::SYMBOL_BITS;
  localparam int WB = hspq_pkg::WEIGHT_BITS;
  localparam int CW = hspq_pkg::CNT_W;

  state_t              state, state_next;
  logic [CW-1:0]       held_count, held_count_next;
  hspq_pkg::in_t       cmd_q;
  hspq_pkg::out_t      result_next;
  hspq_pkg::cell_ctl_t ctl;

  logic [SB-1:0] cell_symbol [N];
  logic [WB-1:0] cell_weight [N];
  logic [N-1:0]  cell_le_now;
  logic [N-1:0]  cell_le;
  logic [N-1:0]  cell_dup;
  logic [N-1:0]  occupied;
  logic          dup_any;
  logic          do_insert;
  logic          do_remove;
  logic          accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Sequencer: compare, gather, apply.
  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_CMP : S_IDLE;
      S_CMP:   state_next = S_RED;
      S_RED:   state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      done       <= (state == S_APPLY);
    end
  end

  // Item and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (state == S_APPLY) begin
      result <= result_next;
    end
  end

  // Slots below the count hold entries.
  for (genvar i = 0; i < N; i++) begin : g_occ
    localparam logic [CW-1:0] IDX = CW'(i);
    assign occupied[i] = (IDX < held_count);
  end

  // Status decision and count update in the apply cycle.
  always_comb begin
    do_insert       = 1'b0;
    do_remove       = 1'b0;
    held_count_next = held_count;
    result_next     = '{status: hspq_pkg::ST_INSERTED, out_symbol: '0, out_weight: '0,
                        occupancy: held_count};
    if (cmd_q.func == hspq_pkg::FUNC_DEQUEUE) begin
      if (held_count == '0) begin
        result_next.status = hspq_pkg::ST_EMPTY;
      end else begin
        result_next.status     = hspq_pkg::ST_DEQUEUED;
        result_next.out_symbol = cell_symbol[0];
        result_next.out_weight = cell_weight[0];
        do_remove              = 1'b1;
        held_count_next        = held_count - CW'(1);
      end
    end else if (dup_any) begin
      result_next.status = hspq_pkg::ST_DUPLICATE;
    end else if (held_count == CW'(N)) begin
      result_next.status = hspq_pkg::ST_FULL;
    end else begin
      do_insert       = 1'b1;
      held_count_next = held_count + CW'(1);
    end
    result_next.occupancy = held_count_next;
    if (state != S_APPLY) begin
      do_insert       = 1'b0;
      do_remove       = 1'b0;
      held_count_next = held_count;
    end
  end

  assign ctl.capture = (state == S_CMP);
  assign ctl.insert  = do_insert;
  assign ctl.remove  = do_remove;

  // The chain of cells; slot 0 is the head.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic          l_le_now;
    logic          l_le;
    logic [SB-1:0] l_symbol;
    logic [WB-1:0] l_weight;
    logic [SB-1:0] r_symbol;
    logic [WB-1:0] r_weight;

    if (i == 0) begin : g_head
      assign l_le_now = 1'b1;
      assign l_le     = 1'b1;
      assign l_symbol = '0;
      assign l_weight = '0;
    end else begin : g_body
      assign l_le_now = cell_le_now[i-1];
      assign l_le     = cell_le[i-1];
      assign l_symbol = cell_symbol[i-1];
      assign l_weight = cell_weight[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_symbol = '0;
      assign r_weight = '0;
    end else begin : g_inner
      assign r_symbol = cell_symbol[i+1];
      assign r_weight = cell_weight[i+1];
    end

    hspq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occupied     (occupied[i]),
      .new_symbol   (cmd_q.symbol),
      .new_weight   (cmd_q.weight),
      .left_le_now  (l_le_now),
      .left_le      (l_le),
      .left_symbol  (l_symbol),
      .left_weight  (l_weight),
      .right_symbol (r_symbol),
      .right_weight (r_weight),
      .symbol       (cell_symbol[i]),
      .weight       (cell_weight[i]),
      .le_now       (cell_le_now[i]),
      .le           (cell_le[i]),
      .dup          (cell_dup[i])
    );
  end

  // Duplicate flags gathered over one registered level.
  hspq_or_tree u_or_tree (
    .clk   (clk),
    .flags (cell_dup),
    .any   (dup_any)
  );

  // An accepted item keeps the unit busy in the following cycle.
  `HSPQ_ASSERT(a_accept_busy, accept |=> busy)
  // Results are spaced apart: never two in consecutive cycles.
  `HSPQ_ASSERT(a_done_single, done |=> !done)
  // The count never exceeds the number of slots.
  `HSPQ_ASSERT(a_count_range, held_count <= CW'(N))
  // Only a dequeue returns a symbol and a weight.
  `HSPQ_ASSERT(a_zero_fields, done && (result.status != hspq_pkg::ST_DEQUEUED) |->
               (result.out_symbol == '0) && (result.out_weight == '0))
  // The reported occupancy matches the count held by the unit.
  `HSPQ_ASSERT(a_occupancy, done |-> result.occupancy == held_count)

endmodule

/* rtl/hspq_cell.sv */
// One slot of the sorted chain: holds an entry, compares it, shifts with its neighbors.
module hspq_cell (
  input  logic                               clk,
  input  hspq_pkg::cell_ctl_t                ctl,
  input  logic                               occupied,
  input  logic [hspq_pkg::SYMBOL_BITS-1:0]   new_symbol,
  input  logic [hspq_pkg::WEIGHT_BITS-1:0]   new_weight,
  input  logic                               left_le_now,
  input  logic                               left_le,
  input  logic [hspq_pkg::SYMBOL_BITS-1:0]   left_symbol,
  input  logic [hspq_pkg::WEIGHT_BITS-1:0]   left_weight,
  input  logic [hspq_pkg::SYMBOL_BITS-1:0]   right_symbol,
  input  logic [hspq_pkg::WEIGHT_BITS-1:0]   right_weight,
  output logic [hspq_pkg::SYMBOL_BITS-1:0]   symbol,
  output logic [hspq_pkg::WEIGHT_BITS-1:0]   weight,
  output logic                               le_now,
  output logic                               le,
  output logic                               dup
);

  logic match_now;

  // The entry sorts at or ahead of the new item when its weight is not greater.
  assign le_now = occupied && (weight <= new_weight);

  // The duplicate scan reaches this slot when every slot ahead of it sorts at or ahead.
  assign match_now = occupied && left_le_now && (new_symbol != '0) && (symbol == new_symbol);

  // Capture the compare flags, then insert or remove by shifting along the chain.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      le  <= le_now;
      dup <= match_now;
    end
    if (ctl.insert) begin
      if (!le) begin
        if (left_le) begin
          symbol <= new_symbol;
          weight <= new_weight;
        end else begin
          symbol <= left_symbol;
          weight <= left_weight;
        end
      end
    end else if (ctl.remove) begin
      symbol <= right_symbol;
      weight <= right_weight;
    end
  end

endmodule

/* rtl/hspq_or_tree.sv */
// Registered two-level OR over the duplicate flags of all cells.
module hspq_or_tree (
  input  logic                          clk,
  input  logic [hspq_pkg::CAPACITY-1:0] flags,
  output logic                          any
);

  localparam int PAD_W = hspq_pkg::GROUP_COUNT * hspq_pkg::GROUP_SIZE;

  logic [PAD_W-1:0]                padded;
  logic [hspq_pkg::GROUP_COUNT-1:0] group_q;

  assign padded = PAD_W'(flags);

  // First level: one registered OR per group of cells.
  always_ff @(posedge clk) begin
    for (int g = 0; g < hspq_pkg::GROUP_COUNT; g++) begin
      group_q[g] <= |padded[g*hspq_pkg::GROUP_SIZE +: hspq_pkg::GROUP_SIZE];
    end
  end

  // Second level: OR of the group results.
  assign any = |group_q;

endmodule

/* bench/hspq_checker.sv */
// Checker that predicts and compares every result of the sorted priority queue unit.
module hspq_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  hspq_pkg::in_t  cmd,
  input  logic           done,
  input  hspq_pkg::out_t result,
  output int             mismatch_count,
  output int             pending_results
);

  // Our own copy of the queue contents, head in slot 0.
  logic [hspq_pkg::SYMBOL_BITS-1:0] held_symbol [hspq_pkg::CAPACITY];
  logic [hspq_pkg::WEIGHT_BITS-1:0] held_weight [hspq_pkg::CAPACITY];
  int                               held_total;

  // Results still owed by the block, oldest first.
  hspq_pkg::out_t awaited_results [$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    held_total      = 0;
  end

  // Applies one item to the queue copy and returns the result it should give.
  function automatic hspq_pkg::out_t sorted_queue_outcome(input hspq_pkg::in_t item);
    hspq_pkg::out_t res;
    int             slot;
    bit             dup;
    res = '0;
    if (item.func == hspq_pkg::FUNC_DEQUEUE) begin
      if (held_total == 0) begin
        res.status = hspq_pkg::ST_EMPTY;
      end else begin
        res.status     = hspq_pkg::ST_DEQUEUED;
        res.out_symbol = held_symbol[0];
        res.out_weight = held_weight[0];
        for (int i = 0; i < held_total - 1; i++) begin
          held_symbol[i] = held_symbol[i+1];
          held_weight[i] = held_weight[i+1];
        end
        held_total--;
      end
    end else begin
      // The scan stops after the first entry of greater weight, which is still
      // checked for a repeated symbol.
      slot = held_total;
      dup  = 1'b0;
      for (int i = 0; i < held_total; i++) begin
        if (item.symbol != '0 && held_symbol[i] == item.symbol) begin
          dup = 1'b1;
          break;
        end
        if (held_weight[i] > item.weight) begin
          slot = i;
          break;
        end
      end
      if (dup) begin
        res.status = hspq_pkg::ST_DUPLICATE;
      end else if (held_total >= hspq_pkg::CAPACITY) begin
        res.status = hspq_pkg::ST_FULL;
      end else begin
        for (int i = held_total; i > slot; i--) begin
          held_symbol[i] = held_symbol[i-1];
          held_weight[i] = held_weight[i-1];
        end
        held_symbol[slot] = item.symbol;
        held_weight[slot] = item.weight;
        held_total++;
        res.status = hspq_pkg::ST_INSERTED;
      end
    end
    res.occupancy = held_total[hspq_pkg::CNT_W-1:0];
    return res;
  endfunction

  task automatic compare_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  // Results are checked before a new item is predicted, since a result and the
  // next item can share one edge.
  always @(posedge clk) begin
    hspq_pkg::out_t want;
    if (rst) begin
      held_total = 0;
      awaited_results.delete();
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no item outstanding, status %0d", $time,
                   result.status);
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", 64'(want.status), 64'(result.status));
          compare_field("out_symbol", 64'(want.out_symbol), 64'(result.out_symbol));
          compare_field("out_weight", 64'(want.out_weight), 64'(result.out_weight));
          compare_field("occupancy", 64'(want.occupancy), 64'(result.occupancy));
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(sorted_queue_outcome(cmd));
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

/* bench/tb_top.sv */
// Stimulus and verdict for the sorted priority queue unit.
module tb_top;

  localparam int PHASE_ITEMS = 320;
  localparam int FILL_ITEMS  = 270;
  localparam int SB          = hspq_pkg::SYMBOL_BITS;
  localparam int WB          = hspq_pkg::WEIGHT_BITS;

  logic           clk;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  hspq_pkg::in_t  cmd   = '0;
  logic           busy;
  logic           done;
  hspq_pkg::out_t result;
  int             mismatch_count;
  int             pending_results;
  int             idle_pct = 0;

  huffman_sorted_priority_queue_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  hspq_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .done            (done),
    .result          (result),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic hspq_pkg::in_t make_item(input hspq_pkg::func_t f,
                                              input logic [SB-1:0] s,
                                              input logic [WB-1:0] w);
    hspq_pkg::in_t it;
    it.func   = f;
    it.symbol = s;
    it.weight = w;
    return it;
  endfunction

  // Symbols lean on internal nodes and a small alphabet so repeats are common.
  function automatic logic [SB-1:0] pick_symbol();
    case ($urandom_range(9))
      0, 1, 2:    return '0;
      3, 4, 5, 6: return SB'($urandom_range(1, 12));
      default:    return SB'($urandom_range(1, 255));
    endcase
  endfunction

  // Weights mix tight ranges for ties with extremes and full-range values.
  function automatic logic [WB-1:0] pick_weight();
    case ($urandom_range(9))
      0, 1, 2, 3: return WB'($urandom_range(0, 7));
      4:          return '0;
      5:          return '1;
      6:          return WB'(32'd1 << $urandom_range(31));
      default:    return WB'($urandom);
    endcase
  endfunction

  function automatic hspq_pkg::in_t random_item(input int enq_pct);
    hspq_pkg::func_t f;
    f = ($urandom_range(99) < enq_pct) ? hspq_pkg::FUNC_ENQUEUE : hspq_pkg::FUNC_DEQUEUE;
    return make_item(f, pick_symbol(), pick_weight());
  endfunction

  // Offers one item, idling first at random, and returns at the accepting edge.
  task automatic issue(input hspq_pkg::in_t item);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd   <= make_item(hspq_pkg::func_t'($urandom_range(1)), SB'($urandom),
                         WB'($urandom));
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= item;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int enq_pct;
    int sent;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dequeue, ties, internal nodes, extremes, front insert,
    // duplicate among lower weights, duplicate on the first heavier entry and a
    // repeated symbol past that entry, then a full drain.
    issue(make_item(hspq_pkg::FUNC_DEQUEUE, 8'd0, 32'd0));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd65, 32'd5));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd0, 32'd5));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd0, 32'd5));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd66, 32'd5));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd255, 32'hFFFF_FFFF));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd1, 32'd0));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd65, 32'd9));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd255, 32'd3));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd66, 32'd4));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd65, 32'd4));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd0, 32'hFFFF_FFFF));
    issue(make_item(hspq_pkg::FUNC_ENQUEUE, 8'd0, 32'd0));
    repeat (12) issue(make_item(hspq_pkg::FUNC_DEQUEUE, 8'hFF, 32'hFFFF_FFFF));

    // Random runs that swing the occupancy up and down, under three idle rates.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 29 : (phase == 1) ? 83 : 0;
      sent     = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(2))
          0:       enq_pct = 85;
          1:       enq_pct = 50;
          default: enq_pct = 20;
        endcase
        repeat ($urandom_range(8, 40)) begin
          issue(random_item(enq_pct));
          sent++;
        end
      end
    end

    // Internal nodes are never repeats, so this burst always reaches capacity;
    // the named symbols after it are then either repeats or dropped as full.
    repeat (FILL_ITEMS) issue(make_item(hspq_pkg::FUNC_ENQUEUE, '0, pick_weight()));
    repeat (10) issue(make_item(hspq_pkg::FUNC_ENQUEUE, SB'($urandom_range(1, 255)),
                                pick_weight()));
    repeat (FILL_ITEMS) issue(random_item(10));

    // Let every owed result arrive, then keep watching for strays.
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
